### rtl/core/pqmr_pkg.sv
// ----------------------------------------------------------------------------
// pqmr_pkg
// Shared types and constants of the priority queue: sizes, opcodes, status
// codes, entry and result records, and sequencer states.
// ----------------------------------------------------------------------------
package pqmr_pkg;

  localparam int CAPACITY      = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int PRIORITY_BITS = 8;
  localparam int IDX_BITS      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS      = $clog2(CAPACITY + 1);
  localparam int ENTRY_BITS    = PAYLOAD_BITS + PRIORITY_BITS;

  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(CAPACITY);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0]  payload;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    status_t status;
    entry_t  entry;
    logic    last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_INIT,
    S_SHIFT,
    S_LIST_RD,
    S_LIST_DAT,
    S_RESP
  } state_t;

endpackage

### rtl/core/pqmr_in_if.sv
// ----------------------------------------------------------------------------
// pqmr_in_if
// Command channel of the priority queue: opcode with payload and priority.
// ----------------------------------------------------------------------------
interface pqmr_in_if
  import pqmr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic [PAYLOAD_BITS-1:0]  payload_in;
  logic [PRIORITY_BITS-1:0] priority_in;

  modport source (output valid, output opcode, output payload_in, output priority_in,
                  input ready);
  modport sink   (input valid, input opcode, input payload_in, input priority_in,
                  output ready);
endinterface

### rtl/core/pqmr_out_if.sv
// ----------------------------------------------------------------------------
// pqmr_out_if
// Result channel of the priority queue: status, entry and last marker.
// ----------------------------------------------------------------------------
interface pqmr_out_if
  import pqmr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [PAYLOAD_BITS-1:0]  payload_out;
  logic [PRIORITY_BITS-1:0] priority_out;
  logic                     last;

  modport source (output valid, output status, output payload_out, output priority_out,
                  output last, input ready);
  modport sink   (input valid, input status, input payload_out, input priority_out,
                  input last, output ready);
endinterface

### rtl/core/pqmr_ram.sv
// ----------------------------------------------------------------------------
// pqmr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pqmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/core/pqmr_seq.sv
// ----------------------------------------------------------------------------
// pqmr_seq
// Sequencer of the priority queue: one priority comparator, entry count and
// RAM pointers; appends inserts, scans for the maximum, closes the gap, walks the list.
// ----------------------------------------------------------------------------
module pqmr_seq
  import pqmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  pqmr_in_if.sink               cmd,
  output logic                  ram_we,
  output logic [IDX_BITS-1:0]   ram_waddr,
  output entry_t                ram_wdata,
  output logic                  ram_re,
  output logic [IDX_BITS-1:0]   ram_raddr,
  input  entry_t                ram_rdata,
  output logic                  res_valid,
  output result_t               res,
  input  logic                  res_take
);
  state_t                state, state_next;
  logic [CNT_BITS-1:0]   count, count_next;
  logic [CNT_BITS-1:0]   idx, idx_next;
  logic [IDX_BITS-1:0]   widx, widx_next;
  logic [IDX_BITS-1:0]   best_idx, best_idx_next;
  entry_t                best_entry, best_entry_next;
  result_t               res_reg, res_next;
  logic [CNT_BITS-1:0]   idx_dec;
  logic [CNT_BITS-1:0]   best_ext;
  logic                  greater;

  assign idx_dec  = idx - CNT_BITS'(1);
  assign best_ext = CNT_BITS'(best_idx);
  assign greater  = ram_rdata.prio > best_entry.prio;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    widx       <= widx_next;
    best_idx   <= best_idx_next;
    best_entry <= best_entry_next;
    res_reg    <= res_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    widx_next       = widx;
    best_idx_next   = best_idx;
    best_entry_next = best_entry;
    res_next        = res_reg;
    cmd.ready       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = count[IDX_BITS-1:0];
    ram_wdata       = '{payload: cmd.payload_in, prio: cmd.priority_in};
    ram_re          = 1'b0;
    ram_raddr       = idx[IDX_BITS-1:0];
    res_valid       = 1'b0;
    res             = res_reg;

    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          case (opcode_t'(cmd.opcode))
            OP_INSERT: begin
              state_next = S_RESP;
              if (count == CNT_FULL) begin
                res_next = '{status: ST_FULL, entry: '0, last: 1'b1};
              end else begin
                ram_we     = 1'b1;
                count_next = count + CNT_BITS'(1);
                res_next   = '{status: ST_OK, entry: '0, last: 1'b1};
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                res_next   = '{status: ST_EMPTY, entry: '0, last: 1'b1};
                state_next = S_RESP;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                idx_next   = CNT_BITS'(1);
                state_next = S_SCAN;
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                res_next   = '{status: ST_EMPTY, entry: '0, last: 1'b1};
                state_next = S_RESP;
              end else begin
                idx_next   = count;
                state_next = S_LIST_RD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // strict compare keeps the oldest among equal priorities
        if (idx == CNT_BITS'(1) || greater) begin
          best_idx_next   = idx_dec[IDX_BITS-1:0];
          best_entry_next = ram_rdata;
        end
        if (idx != count) begin
          ram_re    = 1'b1;
          ram_raddr = idx[IDX_BITS-1:0];
          idx_next  = idx + CNT_BITS'(1);
        end else begin
          state_next = S_SHIFT_INIT;
        end
      end
      S_SHIFT_INIT: begin
        if (best_ext + CNT_BITS'(1) < count) begin
          ram_re     = 1'b1;
          ram_raddr  = best_idx + IDX_BITS'(1);
          widx_next  = best_idx;
          idx_next   = best_ext + CNT_BITS'(2);
          state_next = S_SHIFT;
        end else begin
          count_next = count - CNT_BITS'(1);
          res_next   = '{status: ST_OK, entry: best_entry, last: 1'b1};
          state_next = S_RESP;
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = widx;
        ram_wdata = ram_rdata;
        widx_next = widx + IDX_BITS'(1);
        if (idx != count) begin
          ram_re    = 1'b1;
          ram_raddr = idx[IDX_BITS-1:0];
          idx_next  = idx + CNT_BITS'(1);
        end else begin
          count_next = count - CNT_BITS'(1);
          res_next   = '{status: ST_OK, entry: best_entry, last: 1'b1};
          state_next = S_RESP;
        end
      end
      S_LIST_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = idx_dec[IDX_BITS-1:0];
        state_next = S_LIST_DAT;
      end
      S_LIST_DAT: begin
        res_valid = 1'b1;
        res       = '{status: ST_OK, entry: ram_rdata, last: (idx == CNT_BITS'(1))};
        if (res_take) begin
          if (idx == CNT_BITS'(1)) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_dec;
            state_next = S_LIST_RD;
          end
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + CNT_BITS'(1) || count + CNT_BITS'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_shift_gap: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> (CNT_BITS'(widx) + CNT_BITS'(2) == idx))
    else $error("shift write and read pointers out of step");

  a_list_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST_RD || state == S_LIST_DAT) |-> (idx != '0 && idx <= count))
    else $error("list pointer outside stored entries");

  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (idx != '0 && idx <= count))
    else $error("scan pointer outside stored entries");
endmodule

### rtl/core/priority_queue_max_remove.sv
// Insert, or remove or list on an empty queue, gives its result through S_RESP and the output register.
// Remove scans every stored entry, then shifts each entry behind the winner down one place.
// List gives its results newest first, holding while the output stalls; opcode 3 gives no result.
// One command at a time, with the single priority comparator and RAM read port.
// Reset clears the state, entry count and output valid; entry storage stays undefined and is never cleared.
// ----------------------------------------------------------------------------
// priority_queue_max_remove
// Bounded priority queue with linear-scan removal of the highest priority
// entry, oldest first among equals, and a newest-first listing.
// ----------------------------------------------------------------------------
module priority_queue_max_remove
  import pqmr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  pqmr_in_if.sink  cmd,
  pqmr_out_if.source rsp
);
  logic                ram_we;
  logic [IDX_BITS-1:0] ram_waddr;
  entry_t              ram_wdata;
  logic                ram_re;
  logic [IDX_BITS-1:0] ram_raddr;
  entry_t              ram_rdata;
  logic                res_valid;
  result_t             res;
  logic                res_take;
  logic                out_valid;
  result_t             out_data;

  pqmr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  pqmr_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register, reloads in the cycle its transfer completes
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_data.status;
  assign rsp.payload_out  = out_data.entry.payload;
  assign rsp.priority_out = out_data.entry.prio;
  assign rsp.last         = out_data.last;
endmodule
